// ===== hw/rtl/byte_fifo_with_read_checkpoint_assert.svh =====
// Assertion macros shared by the byte FIFO RTL.
`ifndef BYTE_FIFO_WITH_READ_CHECKPOINT_ASSERT_SVH
`define BYTE_FIFO_WITH_READ_CHECKPOINT_ASSERT_SVH

`ifndef ASSERT_OFF

// expr holds at every clock edge out of reset
`define BFC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// cons holds in the same cycle as ante
`define BFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// cons holds in the cycle after ante
`define BFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BFC_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define BFC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define BFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/bfc_pkg.sv =====
// Types and constants for the byte FIFO with read checkpoint.
package bfc_pkg;

    localparam int SIZE_W = 9;
    localparam int FILL_W = 9;
    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BACKUP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RECOVER = 3'd4;

    localparam logic [SIZE_W-1:0] SIZE_MIN = 9'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_in;
    } cmd_t;

    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] read_data;
        logic [FILL_W-1:0] fill_level;
    } rsp_t;

    // result of a command, waiting on the RAM read data
    typedef struct packed {
        logic              status;
        logic              rd_ok;
        logic [FILL_W-1:0] fill;
    } stage_t;

endpackage

// ===== hw/rtl/byte_fifo_with_read_checkpoint.sv =====
// Byte FIFO with read checkpoint: top level with result staging.
//
// Command channel (cmd_valid/cmd_stall, payload cmd): one command per word,
// kind write, read, flush, backup or recover, plus a data byte for writes.
// Response channel (rsp_valid/rsp_stall, payload rsp): exactly one word per
// command, in order: status (1 = full on write, empty on read, or bad kind),
// the byte taken by a successful read (else zero) and the fill level after it.
// Config: cfg_we writes cfg_data into the size register (clamped to 2..DEPTH)
// that sets where the pointers wrap; write it only while the block is idle.
// Each accepted command's result is registered into the result stage together
// with the storage RAM read data, then moves into the output register.
// Throughput: one command per cycle while rsp_stall is low; the RAM takes
// one write or one read each cycle.
// Stall: a stalled response holds; one more command is accepted into the
// result stage behind it, after which cmd_stall rises until rsp drains.
// Reset: pointers, count and checkpoint clear, size goes to min(256, DEPTH);
// storage contents are not cleared and no clearing pass is needed.
`include "byte_fifo_with_read_checkpoint_assert.svh"

module byte_fifo_with_read_checkpoint #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_stall,
    input  bfc_pkg::cmd_t              cmd,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output bfc_pkg::rsp_t              rsp,
    input  logic                       cfg_we,
    input  logic [bfc_pkg::SIZE_W-1:0] cfg_data
);

    import bfc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              acc;
    logic              out_free;
    logic              s1_move;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_q;
    stage_t            res;

    logic   s1_valid_reg,  s1_valid_next;
    stage_t s1_reg;
    logic   out_valid_reg, out_valid_next;
    rsp_t   out_reg;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign cmd_stall = s1_valid_reg && !out_free;
    assign acc       = cmd_valid && !cmd_stall;

    bfc_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .res       (res)
    );

    bfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // RAM data stays put while the stage holds, since no read issues then
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg <= res;
        end
        if (out_free)
        begin
            out_reg.status     <= s1_reg.status;
            out_reg.read_data  <= s1_reg.rd_ok ? ram_q : '0;
            out_reg.fill_level <= s1_reg.fill;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `BFC_ASSERT_IMPLY(a_stall_full, clk, rst_n, cmd_stall, s1_valid_reg && out_valid_reg)
    `BFC_ASSERT_NEXT(a_stage_fill, clk, rst_n, acc, s1_valid_reg)

endmodule

// ===== hw/rtl/bfc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bfc_ctrl.sv =====
// Command decode, pointer/count/checkpoint registers and RAM port control.
`include "byte_fifo_with_read_checkpoint_assert.svh"

module bfc_ctrl #(
    parameter int DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          acc,
    input  bfc_pkg::cmd_t                 cmd,
    input  logic                          cfg_we,
    input  logic [bfc_pkg::SIZE_W-1:0]    cfg_data,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [bfc_pkg::BYTE_W-1:0]    ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    output bfc_pkg::stage_t               res
);

    import bfc_pkg::*;

    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
    localparam int SIZE_RST = (DEPTH < 256) ? DEPTH : 256;

    logic [SIZE_W-1:0] size_reg,    size_next;
    logic [AW-1:0]     rd_idx_reg,  rd_idx_next;
    logic [AW-1:0]     wr_idx_reg,  wr_idx_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;
    logic [AW-1:0]     sv_idx_reg,  sv_idx_next;
    logic [FILL_W-1:0] sv_fill_reg, sv_fill_next;

    logic          full;
    logic          empty;
    logic [CW-1:0] rd_inc;
    logic [CW-1:0] wr_inc;
    logic [AW-1:0] rd_adv;
    logic [AW-1:0] wr_adv;
    logic          status;
    logic          rd_ok;
    logic          wr_ok;

    assign full  = (fill_reg >= size_reg);
    assign empty = (fill_reg == '0);

    // indices wrap to zero at size or beyond
    assign rd_inc = CW'(rd_idx_reg) + CW'(1);
    assign wr_inc = CW'(wr_idx_reg) + CW'(1);
    assign rd_adv = (rd_inc >= CW'(size_reg)) ? '0 : rd_inc[AW-1:0];
    assign wr_adv = (wr_inc >= CW'(size_reg)) ? '0 : wr_inc[AW-1:0];

    always_comb
    begin
        size_next = size_reg;
        if (cfg_we)
        begin
            if (cfg_data < SIZE_MIN)
            begin
                size_next = SIZE_MIN;
            end
            else if (CW'(cfg_data) > CW'(DEPTH))
            begin
                size_next = SIZE_W'(DEPTH);
            end
            else
            begin
                size_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        fill_next    = fill_reg;
        sv_idx_next  = sv_idx_reg;
        sv_fill_next = sv_fill_reg;
        status       = 1'b0;
        rd_ok        = 1'b0;
        wr_ok        = 1'b0;
        unique case (cmd.kind)
            KIND_WRITE:
            begin
                if (full)
                begin
                    status = 1'b1;
                end
                else
                begin
                    wr_ok       = 1'b1;
                    fill_next   = fill_reg + FILL_W'(1);
                    wr_idx_next = wr_adv;
                end
            end
            KIND_READ:
            begin
                if (empty)
                begin
                    status = 1'b1;
                end
                else
                begin
                    rd_ok       = 1'b1;
                    fill_next   = fill_reg - FILL_W'(1);
                    rd_idx_next = rd_adv;
                end
            end
            KIND_FLUSH:
            begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                fill_next   = '0;
            end
            KIND_BACKUP:
            begin
                sv_idx_next  = rd_idx_reg;
                sv_fill_next = fill_reg;
            end
            KIND_RECOVER:
            begin
                rd_idx_next = sv_idx_reg;
                fill_next   = sv_fill_reg;
            end
            default:
            begin
                status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= SIZE_W'(SIZE_RST);
            rd_idx_reg  <= '0;
            wr_idx_reg  <= '0;
            fill_reg    <= '0;
            sv_idx_reg  <= '0;
            sv_fill_reg <= '0;
        end
        else
        begin
            size_reg <= size_next;
            if (acc)
            begin
                rd_idx_reg  <= rd_idx_next;
                wr_idx_reg  <= wr_idx_next;
                fill_reg    <= fill_next;
                sv_idx_reg  <= sv_idx_next;
                sv_fill_reg <= sv_fill_next;
            end
        end
    end

    assign ram_we    = acc && wr_ok;
    assign ram_waddr = wr_idx_reg;
    assign ram_wdata = cmd.data_in;
    assign ram_re    = acc && rd_ok;
    assign ram_raddr = rd_idx_reg;

    assign res.status = status;
    assign res.rd_ok  = rd_ok;
    assign res.fill   = fill_next;

    `BFC_ASSERT_NEXT(a_wr_count, clk, rst_n, acc && (cmd.kind == KIND_WRITE) && !full,
        fill_reg == $past(fill_reg) + FILL_W'(1))
    `BFC_ASSERT_NEXT(a_rd_empty_hold, clk, rst_n, acc && (cmd.kind == KIND_READ) && empty,
        $stable(rd_idx_reg) && $stable(fill_reg))
    `BFC_ASSERT_NEXT(a_flush_clear, clk, rst_n, acc && (cmd.kind == KIND_FLUSH),
        (fill_reg == '0) && (wr_idx_reg == '0) && (rd_idx_reg == '0))
    `BFC_ASSERT_ALWAYS(a_ram_port, clk, rst_n, !(ram_we && ram_re))

endmodule

// ===== verif/byte_fifo_with_read_checkpoint_tb.sv =====
// Self-checking testbench for the byte FIFO with read checkpoint.
`timescale 1ns / 1ps

module byte_fifo_with_read_checkpoint_tb;
    import bfc_pkg::*;

    localparam int DEPTH      = 256;
    localparam int CLK_HALF   = 4;
    localparam int RST_CYCLES = 7;
    localparam int IDLE_LIMIT = 4000;
    localparam int ITEM_GOAL  = 1750;
    localparam int HOLD_AT    = 600;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_SHOWN  = 10;

    typedef enum logic [1:0] {
        ENTRY_CMD,
        ENTRY_CFG,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t       what;
        logic [SIZE_W-1:0] cfg_val;
        cmd_t              c;
    } pending_word_t;

    // shadow of the FIFO state
    typedef struct {
        logic [DEPTH-1:0][BYTE_W-1:0] mem;
        logic [DEPTH-1:0]             written;
        logic [7:0]                   rd_idx;
        logic [7:0]                   wr_idx;
        logic [7:0]                   saved_rd;
        logic [FILL_W-1:0]            fill;
        logic [FILL_W-1:0]            saved_fill;
        logic [SIZE_W-1:0]            size;
    } fifo_model_t;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_stall;
    cmd_t              cmd;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_t              rsp;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_data;

    pending_word_t pending[$];
    rsp_t          expected_rsp[$];
    fifo_model_t   gen_model;
    fifo_model_t   dut_model;

    int error_cnt;
    int checked_cnt;
    int gen_cnt;

    // driver state
    int            gap_left;
    int            burst_left;
    int            idle_edges;
    logic          nxt_valid;
    cmd_t          nxt_cmd;
    logic          nxt_we;
    logic [SIZE_W-1:0] nxt_cfg;
    pending_word_t head;

    // receiver state
    int   stall_left;
    int   run_left;
    logic hold_done;
    logic nxt_stall;
    int   pick;

    byte_fifo_with_read_checkpoint #(
        .DEPTH(DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
        if (v < SIZE_MIN)
            return SIZE_MIN;
        if (v > DEPTH)
            return SIZE_W'(DEPTH);
        return v;
    endfunction

    function automatic logic [7:0] next_index(logic [7:0] idx, logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] n;
        n = {1'b0, idx} + 1'b1;
        return (n >= size) ? 8'd0 : n[7:0];
    endfunction

    task automatic model_reset(output fifo_model_t m);
        m.mem        = '0;
        m.written    = '0;
        m.rd_idx     = '0;
        m.wr_idx     = '0;
        m.saved_rd   = '0;
        m.fill       = '0;
        m.saved_fill = '0;
        m.size       = clamp_size(SIZE_W'(256));
    endtask

    function automatic rsp_t fifo_step(inout fifo_model_t m, input cmd_t c);
        rsp_t r;
        r = '0;
        case (c.kind)
            KIND_WRITE:
                if (m.fill >= m.size)
                    r.status = 1'b1;
                else
                begin
                    m.fill              = m.fill + 1'b1;
                    m.mem[m.wr_idx]     = c.data_in;
                    m.written[m.wr_idx] = 1'b1;
                    m.wr_idx            = next_index(m.wr_idx, m.size);
                end
            KIND_READ:
                if (m.fill == 0)
                    r.status = 1'b1;
                else
                begin
                    m.fill      = m.fill - 1'b1;
                    r.read_data = m.mem[m.rd_idx];
                    m.rd_idx    = next_index(m.rd_idx, m.size);
                end
            KIND_FLUSH:
            begin
                m.rd_idx = '0;
                m.wr_idx = '0;
                m.fill   = '0;
            end
            KIND_BACKUP:
            begin
                m.saved_rd   = m.rd_idx;
                m.saved_fill = m.fill;
            end
            KIND_RECOVER:
            begin
                // write index is left alone
                m.rd_idx = m.saved_rd;
                m.fill   = m.saved_fill;
            end
            default:
                r.status = 1'b1;
        endcase
        r.fill_level = m.fill;
        return r;
    endfunction

    // stimulus building; gen_model tracks the stream so no unwritten entry is read
    task automatic add_cmd(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
        pending_word_t w;
        if (kind == KIND_READ && gen_model.fill != 0 && !gen_model.written[gen_model.rd_idx])
            kind = KIND_WRITE;
        w.what    = ENTRY_CMD;
        w.cfg_val = '0;
        w.c.kind  = kind;
        w.c.data_in = data;
        void'(fifo_step(gen_model, w.c));
        pending.push_back(w);
        gen_cnt++;
    endtask

    task automatic add_cfg(logic [SIZE_W-1:0] v);
        pending_word_t w;
        w.what    = ENTRY_CFG;
        w.cfg_val = v;
        w.c       = '0;
        gen_model.size = clamp_size(v);
        pending.push_back(w);
    endtask

    task automatic add_drain();
        pending_word_t w;
        w      = '0;
        w.what = ENTRY_DRAIN;
        pending.push_back(w);
    endtask

    task automatic add_random_cmd(int wr_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            add_cmd(KIND_FLUSH, BYTE_W'($urandom));
        else if (r < 11)
            add_cmd(KIND_BACKUP, BYTE_W'($urandom));
        else if (r < 18)
            add_cmd(KIND_RECOVER, BYTE_W'($urandom));
        else if (r < 22)
            add_cmd(KIND_W'($urandom_range(5, 7)), BYTE_W'($urandom));
        else if ($urandom_range(0, 99) < wr_pct)
            add_cmd(KIND_WRITE, BYTE_W'($urandom));
        else
            add_cmd(KIND_READ, BYTE_W'($urandom));
    endtask

    // fill to full and beyond, then empty and one past
    task automatic add_fill_sweep();
        add_cmd(KIND_FLUSH, 8'h00);
        while (gen_model.fill < gen_model.size)
            add_cmd(KIND_WRITE, BYTE_W'($urandom));
        add_cmd(KIND_WRITE, BYTE_W'($urandom));
        add_cmd(KIND_WRITE, BYTE_W'($urandom));
        repeat (int'(gen_model.size) + 1)
            add_cmd(KIND_READ, BYTE_W'($urandom));
    endtask

    task automatic build_stimulus();
        logic [SIZE_W-1:0] sz;
        int                p;
        int                sel;
        // directed: empty read, backup/recover replay, flush, unused kinds
        add_cmd(KIND_READ, 8'hFF);
        add_cmd(KIND_WRITE, 8'h00);
        add_cmd(KIND_WRITE, 8'hFF);
        add_cmd(KIND_BACKUP, 8'h00);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_RECOVER, 8'hFF);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_FLUSH, 8'hFF);
        add_cmd(3'd5, 8'hFF);
        add_cmd(3'd6, 8'h00);
        add_cmd(3'd7, 8'hFF);
        // size below range clamps to minimum: full, wrap, recover
        add_cfg(9'd0);
        add_cmd(KIND_WRITE, 8'hA5);
        add_cmd(KIND_WRITE, 8'h5A);
        add_cmd(KIND_WRITE, 8'h3C);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_WRITE, 8'hC3);
        add_cmd(KIND_BACKUP, 8'h00);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_RECOVER, 8'h00);
        add_cmd(KIND_READ, 8'h00);
        add_cmd(KIND_READ, 8'h00);

        p = 0;
        while (gen_cnt < ITEM_GOAL)
        begin
            sel = -1;
            case (p)
                0: sz = 9'd511;
                1: sz = 9'd2;
                2: sz = 9'd1;
                3: sz = 9'd3;
                4: sz = 9'd256;
                5: sz = 9'd257;
                6: sz = 9'd300;
                default:
                begin
                    sel = $urandom_range(0, 3);
                    case (sel)
                        0: sz = SIZE_W'($urandom_range(2, 16));
                        1: sz = SIZE_W'($urandom_range(2, 256));
                        default: sz = SIZE_W'($urandom_range(0, 511));
                    endcase
                end
            endcase
            if (sel == 3)
                add_drain();
            else
                add_cfg(sz);
            if (p == 0 || $urandom_range(0, 99) < 25)
                add_fill_sweep();
            repeat ($urandom_range(60, 160))
                add_random_cmd($urandom_range(25, 85));
            p++;
        end
    endtask

    task automatic pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            gap_left = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
                gap_left = $urandom_range(1, 2);
            else if (r < 95)
                gap_left = $urandom_range(3, 8);
            else
                gap_left = $urandom_range(20, 60);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic report(string msg);
        error_cnt++;
        if (error_cnt <= MAX_SHOWN)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic check_rsp(rsp_t got);
        rsp_t want;
        if (expected_rsp.size() == 0)
        begin
            report($sformatf("response word with no command outstanding: st=%0d rd=%02h fill=%0d",
                             got.status, got.read_data, got.fill_level));
        end
        else
        begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.read_data !== want.read_data ||
                got.fill_level !== want.fill_level)
                report($sformatf("word %0d: exp st=%0d rd=%02h fill=%0d, got st=%0d rd=%02h fill=%0d",
                                 checked_cnt, want.status, want.read_data, want.fill_level,
                                 got.status, got.read_data, got.fill_level));
            checked_cnt++;
        end
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid  <= 1'b0;
            cmd        <= '0;
            cfg_we     <= 1'b0;
            cfg_data   <= '0;
            gap_left   = 0;
            burst_left = 0;
            idle_edges = 0;
        end
        else
        begin
            nxt_valid = cmd_valid;
            nxt_cmd   = cmd;
            nxt_we    = 1'b0;
            nxt_cfg   = cfg_data;
            if (cmd_valid && !cmd_stall)
            begin
                expected_rsp.push_back(fifo_step(dut_model, cmd));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid)
            begin
                if (expected_rsp.size() == 0 && !cmd_valid && !cfg_we)
                    idle_edges++;
                else
                    idle_edges = 0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() != 0)
                begin
                    head = pending[0];
                    if (head.what == ENTRY_CMD)
                    begin
                        nxt_valid = 1'b1;
                        nxt_cmd   = head.c;
                        void'(pending.pop_front());
                        pick_gap();
                    end
                    else if (idle_edges >= 2)
                    begin
                        // register write or pause only once all words are back
                        if (head.what == ENTRY_CFG)
                        begin
                            nxt_we         = 1'b1;
                            nxt_cfg        = head.cfg_val;
                            dut_model.size = clamp_size(head.cfg_val);
                        end
                        void'(pending.pop_front());
                        idle_edges = 0;
                    end
                end
            end
            cmd_valid <= nxt_valid;
            cmd       <= nxt_cmd;
            cfg_we    <= nxt_we;
            cfg_data  <= nxt_cfg;
        end
    end

    // response monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left = 0;
            run_left   = 0;
            hold_done  = 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_rsp(rsp);
            // one long hold-off so the block backs up into the command side
            if (!hold_done && checked_cnt >= HOLD_AT)
            begin
                hold_done  = 1'b1;
                stall_left = HOLD_LEN;
                run_left   = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                nxt_stall = 1'b1;
            end
            else if (run_left > 0)
            begin
                run_left--;
                nxt_stall = 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                nxt_stall = (pick >= 50);
                if (pick < 50)
                    run_left = $urandom_range(1, 40);
                else if (pick < 90)
                    stall_left = $urandom_range(0, 2);
                else if (pick < 98)
                    stall_left = $urandom_range(3, 14);
                else
                    stall_left = $urandom_range(29, 79);
            end
            rsp_stall <= nxt_stall;
        end
    end

    // watchdog on cycles with no word moving
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL byte_fifo_with_read_checkpoint");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        error_cnt   = 0;
        checked_cnt = 0;
        gen_cnt     = 0;
        model_reset(gen_model);
        model_reset(dut_model);
        build_stimulus();
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || cmd_valid || expected_rsp.size() != 0)
            @(posedge clk);
        // catch any stray word after the last one
        repeat (8) @(posedge clk);

        if (error_cnt == 0)
            $display("PASS byte_fifo_with_read_checkpoint");
        else
            $display("FAIL byte_fifo_with_read_checkpoint");
        $finish;
    end

endmodule
